// ===== hw/rtl/gww_pkg.sv =====
// shared types, constants and helpers of the greedy word wrap block
package gww_pkg;

  localparam int PEN_W      = 20;
  localparam int ADV_W      = 17;
  localparam int COL_W      = 16;
  localparam int SB_W       = 17;
  localparam int TALLY_W    = 9;
  localparam int WIDTH_W    = 12;
  localparam int BYTES_W    = 3;
  localparam int TS_W       = 5;
  localparam int LIMIT_W    = 16;
  localparam int ENTRY_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_STOP    = 2'd2;

  localparam logic [LIMIT_W-1:0] WRAP_LIMIT_RST  = 16'hFFFF;
  localparam logic [WIDTH_W-1:0] SPACE_WIDTH_RST = 12'd512;
  localparam logic [TS_W-1:0]    TAB_STOP_RST    = 5'd4;

  localparam logic [PEN_W-1:0]   PEN_MAX   = 20'hFFFFF;
  localparam logic [SB_W-1:0]    NO_SPACE  = 17'h1FFFF;
  localparam logic [TALLY_W-1:0] TALLY_MAX = 9'd256;
  localparam logic [1:0]         MAX_BREAKS = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV,
    ST_TAB_WAIT,
    ST_TEST,
    ST_EMIT_BRK,
    ST_RM_READ,
    ST_RM_DATA,
    ST_RM_TAB,
    ST_RM_ADD,
    ST_COMMIT,
    ST_EMIT_END
  } state_t;

  typedef enum logic [1:0] {
    ADV_IN,
    ADV_ENTRY,
    ADV_TAB
  } adv_src_t;

  typedef struct packed {
    logic     latch_in;
    logic     tab_start;
    logic     tab_from_rm;
    logic     adv_load;
    adv_src_t adv_src;
    logic     emit_brk;
    logic     rm_read;
    logic     rm_skip;
    logic     rm_keep;
    logic     rm_finish;
    logic     commit;
    logic     emit_end;
  } cmd_t;

  typedef struct packed {
    logic item_empty;
    logic item_tab;
    logic item_last;
    logic tab_done;
    logic break_hit;
    logic rm_more;
    logic rm_take;
    logic entry_tab;
    logic slot_free;
  } stat_t;

  function automatic logic [PEN_W-1:0] pen_add(input logic [PEN_W-1:0] x,
                                               input logic [ADV_W-1:0] a);
    logic [PEN_W:0] s;
    s = {1'b0, x} + (PEN_W + 1)'(a);
    pen_add = s[PEN_W] ? PEN_MAX : s[PEN_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/gww_tab_unit.sv =====
// bit-serial tab advance unit: (tab_stop - (x / space_width) mod tab_stop) * space_width
module gww_tab_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gww_pkg::PEN_W-1:0]     x,
  input  logic [gww_pkg::WIDTH_W-1:0]   space_width,
  input  logic [gww_pkg::TS_W-1:0]      tab_stop,
  output logic                          done,
  output logic [gww_pkg::ADV_W-1:0]     adv
);

  logic                            busy;
  logic                            mul_pend;
  logic [4:0]                      cnt;
  logic [gww_pkg::PEN_W-1:0]       xs;
  logic [gww_pkg::WIDTH_W-1:0]     rem;
  logic [gww_pkg::WIDTH_W-1:0]     sw;
  logic [gww_pkg::TS_W-1:0]        ts;
  logic [gww_pkg::TS_W-1:0]        modr;

  logic [gww_pkg::WIDTH_W:0]       t;
  logic                            qbit;
  logic [gww_pkg::WIDTH_W-1:0]     rem_next;
  logic [gww_pkg::TS_W:0]          m2;
  logic [gww_pkg::TS_W-1:0]        modr_next;

  // one quotient bit per cycle, quotient folded into its residue mod ts
  always_comb begin
    t         = {rem, xs[gww_pkg::PEN_W-1]};
    qbit      = (t >= {1'b0, sw});
    rem_next  = qbit ? gww_pkg::WIDTH_W'(t - {1'b0, sw}) : t[gww_pkg::WIDTH_W-1:0];
    m2        = {modr, qbit};
    modr_next = (m2 >= {1'b0, ts}) ? gww_pkg::TS_W'(m2 - {1'b0, ts})
                                   : m2[gww_pkg::TS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      mul_pend <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd0) begin
        busy     <= 1'b0;
        mul_pend <= 1'b1;
      end else if (mul_pend) begin
        mul_pend <= 1'b0;
        done     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sw   <= (space_width == '0) ? gww_pkg::WIDTH_W'(1) : space_width;
      ts   <= (tab_stop == '0) ? gww_pkg::TS_W'(1) : tab_stop;
      xs   <= x;
      rem  <= '0;
      modr <= '0;
      cnt  <= 5'(gww_pkg::PEN_W - 1);
    end else if (busy) begin
      xs   <= {xs[gww_pkg::PEN_W-2:0], 1'b0};
      rem  <= rem_next;
      modr <= modr_next;
      cnt  <= cnt - 5'd1;
    end
    if (mul_pend) begin
      adv <= gww_pkg::ADV_W'(ts - modr) * gww_pkg::ADV_W'(sw);
    end
  end

endmodule

// ===== hw/rtl/gww_datapath.sv =====
// datapath: config, line state, segment glyph buffer, result register
module gww_datapath #(
  parameter int MAX_SEGMENT_GLYPHS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gww_pkg::cmd_t                     cmd,
  output gww_pkg::stat_t                    stat,
  input  logic                              cfg_write,
  input  logic [gww_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gww_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [gww_pkg::WIDTH_W-1:0]       glyph_width,
  input  logic [gww_pkg::BYTES_W-1:0]       glyph_bytes,
  input  logic                              is_space,
  input  logic                              is_tab,
  input  logic                              line_last,
  input  logic                              result_ready,
  output logic                              result_valid,
  output logic [gww_pkg::COL_W-1:0]         break_column,
  output logic                              line_end,
  output logic [gww_pkg::TALLY_W-1:0]       segment_count,
  output logic                              buffer_overflow
);

  localparam int FILL_W   = $clog2(MAX_SEGMENT_GLYPHS + 1);
  localparam int ADDR_W   = $clog2(MAX_SEGMENT_GLYPHS);
  localparam int RM_COL_W = gww_pkg::COL_W + $clog2(MAX_SEGMENT_GLYPHS) + 3;

  logic [gww_pkg::LIMIT_W-1:0]  wrap_limit;
  logic [gww_pkg::WIDTH_W-1:0]  space_width;
  logic [gww_pkg::TS_W-1:0]     tab_stop;

  logic [gww_pkg::WIDTH_W-1:0]  in_w;
  logic [gww_pkg::BYTES_W-1:0]  in_bytes;
  logic                         in_sp;
  logic                         in_tab;
  logic                         in_last;

  logic [FILL_W-1:0]            fill;
  logic [gww_pkg::PEN_W-1:0]    pen_x;
  logic [gww_pkg::COL_W-1:0]    byte_column;
  logic [gww_pkg::COL_W-1:0]    segment_start;
  logic [gww_pkg::SB_W-1:0]     space_break;
  logic [gww_pkg::TALLY_W-1:0]  break_tally;
  logic                         overflow_seen;
  logic [1:0]                   breaks;
  logic [gww_pkg::ADV_W-1:0]    adv;

  logic [FILL_W-1:0]            rm_j;
  logic [FILL_W-1:0]            rm_keep;
  logic [RM_COL_W-1:0]          rm_col;
  logic [gww_pkg::PEN_W-1:0]    rm_x;

  logic [gww_pkg::ENTRY_W-1:0]  mem [MAX_SEGMENT_GLYPHS];
  logic [gww_pkg::ENTRY_W-1:0]  rd_data;

  logic                         tab_done;
  logic [gww_pkg::ADV_W-1:0]    tab_adv;
  logic [gww_pkg::PEN_W-1:0]    tab_x;
  logic [gww_pkg::PEN_W:0]      pen_sum;
  logic [gww_pkg::COL_W-1:0]    brk;
  logic [gww_pkg::BYTES_W-1:0]  entry_bytes;
  logic                         has_room;

  gww_tab_unit u_tab (
    .clk         (clk),
    .rst         (rst),
    .start       (cmd.tab_start),
    .x           (tab_x),
    .space_width (space_width),
    .tab_stop    (tab_stop),
    .done        (tab_done),
    .adv         (tab_adv)
  );

  always_comb begin
    tab_x       = cmd.tab_from_rm ? rm_x : pen_x;
    pen_sum     = {1'b0, pen_x} + (gww_pkg::PEN_W + 1)'(adv);
    entry_bytes = rd_data[14:12];
    has_room    = (fill < FILL_W'(MAX_SEGMENT_GLYPHS));
    if (space_break != gww_pkg::NO_SPACE && space_break > {1'b0, segment_start}) begin
      brk = space_break[gww_pkg::COL_W-1:0];
    end else begin
      brk = byte_column;
    end
    stat.item_empty = (in_bytes == '0);
    stat.item_tab   = in_tab;
    stat.item_last  = in_last;
    stat.tab_done   = tab_done;
    stat.break_hit  = (breaks != gww_pkg::MAX_BREAKS)
                   && (pen_sum > (gww_pkg::PEN_W + 1)'(wrap_limit))
                   && (byte_column > segment_start);
    stat.rm_more    = (rm_j < fill);
    stat.rm_take    = (rm_col >= RM_COL_W'(segment_start));
    stat.entry_tab  = rd_data[15];
    stat.slot_free  = !result_valid || result_ready;
  end

  // control and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_limit    <= gww_pkg::WRAP_LIMIT_RST;
      space_width   <= gww_pkg::SPACE_WIDTH_RST;
      tab_stop      <= gww_pkg::TAB_STOP_RST;
      fill          <= '0;
      pen_x         <= '0;
      byte_column   <= '0;
      segment_start <= '0;
      space_break   <= gww_pkg::NO_SPACE;
      break_tally   <= '0;
      overflow_seen <= 1'b0;
      breaks        <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          gww_pkg::CFG_WRAP_LIMIT:  wrap_limit  <= cfg_data;
          gww_pkg::CFG_SPACE_WIDTH: space_width <= cfg_data[gww_pkg::WIDTH_W-1:0];
          gww_pkg::CFG_TAB_STOP:    tab_stop    <= cfg_data[gww_pkg::TS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.emit_brk || cmd.emit_end) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (cmd.latch_in) begin
        breaks <= '0;
      end
      if (cmd.emit_brk) begin
        breaks        <= breaks + 2'd1;
        if (break_tally < gww_pkg::TALLY_MAX) begin
          break_tally <= break_tally + gww_pkg::TALLY_W'(1);
        end
        segment_start <= brk;
      end
      if (cmd.rm_finish) begin
        fill        <= rm_keep;
        pen_x       <= rm_x;
        space_break <= gww_pkg::NO_SPACE;
      end
      if (cmd.commit) begin
        if (has_room) begin
          fill <= fill + FILL_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
        if (in_sp) begin
          space_break <= gww_pkg::SB_W'(byte_column) + gww_pkg::SB_W'(in_bytes);
        end
        pen_x       <= gww_pkg::pen_add(pen_x, adv);
        byte_column <= byte_column + gww_pkg::COL_W'(in_bytes);
      end
      if (cmd.emit_end) begin
        fill          <= '0;
        pen_x         <= '0;
        byte_column   <= '0;
        segment_start <= '0;
        space_break   <= gww_pkg::NO_SPACE;
        break_tally   <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  // payload: latched glyph, advance, re-measure walk, results
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_w     <= glyph_width;
      in_bytes <= glyph_bytes;
      in_sp    <= is_space;
      in_tab   <= is_tab;
      in_last  <= line_last;
    end
    if (cmd.adv_load) begin
      case (cmd.adv_src)
        gww_pkg::ADV_IN:    adv <= gww_pkg::ADV_W'(in_w);
        gww_pkg::ADV_ENTRY: adv <= gww_pkg::ADV_W'(rd_data[gww_pkg::WIDTH_W-1:0]);
        gww_pkg::ADV_TAB:   adv <= tab_adv;
        default:            adv <= tab_adv;
      endcase
    end
    if (cmd.emit_brk) begin
      break_column    <= brk;
      line_end        <= 1'b0;
      segment_count   <= '0;
      buffer_overflow <= overflow_seen;
      rm_col          <= RM_COL_W'(segment_start);
      rm_j            <= '0;
      rm_keep         <= '0;
      rm_x            <= '0;
    end
    if (cmd.emit_end) begin
      break_column    <= '0;
      line_end        <= 1'b1;
      segment_count   <= break_tally + gww_pkg::TALLY_W'(1);
      buffer_overflow <= overflow_seen;
    end
    if (cmd.rm_skip) begin
      rm_col <= rm_col + RM_COL_W'(entry_bytes);
      rm_j   <= rm_j + FILL_W'(1);
    end
    if (cmd.rm_keep) begin
      rm_x    <= gww_pkg::pen_add(rm_x, adv);
      rm_keep <= rm_keep + FILL_W'(1);
      rm_col  <= rm_col + RM_COL_W'(entry_bytes);
      rm_j    <= rm_j + FILL_W'(1);
    end
  end

  // segment glyph buffer, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.rm_read) begin
      rd_data <= mem[rm_j[ADDR_W-1:0]];
    end
    if (cmd.rm_keep) begin
      mem[rm_keep[ADDR_W-1:0]] <= rd_data;
    end else if (cmd.commit && has_room) begin
      mem[fill[ADDR_W-1:0]] <= {in_tab, in_bytes, in_w};
    end
  end

endmodule

// ===== hw/rtl/gww_ctrl.sv =====
// controller state machine of the greedy word wrap block
module gww_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            glyph_valid,
  output logic            glyph_ready,
  input  gww_pkg::stat_t  stat,
  output gww_pkg::cmd_t   cmd
);

  gww_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gww_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.adv_src = gww_pkg::ADV_IN;
    glyph_ready = 1'b0;
    unique case (state)
      gww_pkg::ST_IDLE: begin
        glyph_ready = 1'b1;
        if (glyph_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = gww_pkg::ST_ADV;
        end
      end
      gww_pkg::ST_ADV: begin
        if (stat.item_empty) begin
          state_next = gww_pkg::ST_EMIT_END;
        end else if (stat.item_tab) begin
          cmd.tab_start = 1'b1;
          state_next    = gww_pkg::ST_TAB_WAIT;
        end else begin
          cmd.adv_load = 1'b1;
          state_next   = gww_pkg::ST_TEST;
        end
      end
      gww_pkg::ST_TAB_WAIT: begin
        if (stat.tab_done) begin
          cmd.adv_load = 1'b1;
          cmd.adv_src  = gww_pkg::ADV_TAB;
          state_next   = gww_pkg::ST_TEST;
        end
      end
      gww_pkg::ST_TEST: begin
        state_next = stat.break_hit ? gww_pkg::ST_EMIT_BRK : gww_pkg::ST_COMMIT;
      end
      gww_pkg::ST_EMIT_BRK: begin
        if (stat.slot_free) begin
          cmd.emit_brk = 1'b1;
          state_next   = gww_pkg::ST_RM_READ;
        end
      end
      gww_pkg::ST_RM_READ: begin
        if (stat.rm_more) begin
          cmd.rm_read = 1'b1;
          state_next  = gww_pkg::ST_RM_DATA;
        end else begin
          cmd.rm_finish = 1'b1;
          state_next    = gww_pkg::ST_ADV;
        end
      end
      gww_pkg::ST_RM_DATA: begin
        if (!stat.rm_take) begin
          cmd.rm_skip = 1'b1;
          state_next  = gww_pkg::ST_RM_READ;
        end else if (stat.entry_tab) begin
          cmd.tab_start   = 1'b1;
          cmd.tab_from_rm = 1'b1;
          state_next      = gww_pkg::ST_RM_TAB;
        end else begin
          cmd.adv_load = 1'b1;
          cmd.adv_src  = gww_pkg::ADV_ENTRY;
          state_next   = gww_pkg::ST_RM_ADD;
        end
      end
      gww_pkg::ST_RM_TAB: begin
        if (stat.tab_done) begin
          cmd.adv_load = 1'b1;
          cmd.adv_src  = gww_pkg::ADV_TAB;
          state_next   = gww_pkg::ST_RM_ADD;
        end
      end
      gww_pkg::ST_RM_ADD: begin
        cmd.rm_keep = 1'b1;
        state_next  = gww_pkg::ST_RM_READ;
      end
      gww_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = stat.item_last ? gww_pkg::ST_EMIT_END : gww_pkg::ST_IDLE;
      end
      gww_pkg::ST_EMIT_END: begin
        if (stat.slot_free) begin
          cmd.emit_end = 1'b1;
          state_next   = gww_pkg::ST_IDLE;
        end
      end
      default: state_next = gww_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/greedy_word_wrap.sv =====
// top level of the greedy word wrap block
//
//  port    dir  handshake                    beat fields
//  glyph   in   glyph_valid / glyph_ready    glyph_width glyph_bytes is_space is_tab line_last
//  result  out  result_valid / result_ready  break_column line_end segment_count buffer_overflow
//  cfg     in   cfg_write                    cfg_index cfg_data
//
// a glyph beat runs advance, break test and commit, then a line end when it closes its line;
//   an empty glyph goes to line end; a tab runs the tab unit's quotient bits and multiply
// a break emits and re-walks the buffer; kept glyphs re-add, kept tabs rerun the tab unit
// reset is synchronous; the fill count guards the buffer, so a glyph is taken as soon
//   as reset is released
// stalls: a break or line end waits while the output register holds an untaken beat
module greedy_word_wrap #(
  parameter int MAX_SEGMENT_GLYPHS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [gww_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gww_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              glyph_valid,
  output logic                              glyph_ready,
  input  logic [gww_pkg::WIDTH_W-1:0]       glyph_width,
  input  logic [gww_pkg::BYTES_W-1:0]       glyph_bytes,
  input  logic                              is_space,
  input  logic                              is_tab,
  input  logic                              line_last,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [gww_pkg::COL_W-1:0]         break_column,
  output logic                              line_end,
  output logic [gww_pkg::TALLY_W-1:0]       segment_count,
  output logic                              buffer_overflow
);

  // command and status between sequencer and datapath
  gww_pkg::cmd_t  cmd;
  gww_pkg::stat_t stat;

  // sequencer: accepts a glyph in idle, runs advance, break test, re-measure, commit, line end
  gww_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .glyph_valid (glyph_valid),
    .glyph_ready (glyph_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // datapath: config registers, line state, glyph buffer, result register
  gww_datapath #(
    .MAX_SEGMENT_GLYPHS (MAX_SEGMENT_GLYPHS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .glyph_width     (glyph_width),
    .glyph_bytes     (glyph_bytes),
    .is_space        (is_space),
    .is_tab          (is_tab),
    .line_last       (line_last),
    .result_ready    (result_ready),
    .result_valid    (result_valid),
    .break_column    (break_column),
    .line_end        (line_end),
    .segment_count   (segment_count),
    .buffer_overflow (buffer_overflow)
  );

endmodule
